@@ rtl/pru_pkg.sv @@
`timescale 1ns / 1ps

package pru_pkg;

    // Fixed field widths of the request and result channels.
    localparam int CODE_W = 32;
    localparam int ELEM_W = 4;
    localparam int LEN_W  = 4;

    // Length register value after reset.
    localparam logic [LEN_W-1:0] LEN_RESET = 4'd12;

    // Request operation codes.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Result kind codes.
    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_DIGIT_W = 4;
    localparam int DIV_STEPS   = CODE_W / DIV_DIGIT_W;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [ELEM_W-1:0] elem_t;

    // Commands from the sequencer to the element pool.
    typedef struct packed {
        logic init;
        logic shift;
        logic rotate;
    } pool_ctl_t;

endpackage

@@ rtl/pru_channels.sv @@
`timescale 1ns / 1ps

// Request channel: one element push or one code to decode.
interface pru_req_if;
    import pru_pkg::*;

    logic  valid;
    logic  ready;
    logic  operation;
    elem_t element_in;
    code_t code_in;

    modport source (output valid, output operation, output element_in, output code_in,
                    input ready);
    modport sink (input valid, input operation, input element_in, input code_in,
                  output ready);
endinterface

// Result channel: a finished code or one decoded element.
interface pru_res_if;
    import pru_pkg::*;

    logic  valid;
    logic  ready;
    logic  result_kind;
    code_t code_out;
    elem_t element_out;
    logic  last;

    modport source (output valid, output result_kind, output code_out, output element_out,
                    output last, input ready);
    modport sink (input valid, input result_kind, input code_out, input element_out,
                  input last, output ready);
endinterface

@@ rtl/pru_divider.sv @@
`timescale 1ns / 1ps

module pru_divider #(
    parameter int DIV_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pru_pkg::code_t      dividend,
    input  logic [DIV_W-1:0]    divisor,
    output logic                done,
    output pru_pkg::code_t      quotient,
    output logic [DIV_W-1:0]    remainder
);
    import pru_pkg::*;

    localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    code_t                 quo_reg, quo_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;

    // Restoring division, several quotient bits per cycle. The dividend shifts
    // out of the top of the quotient register while quotient bits enter below.
    always_comb
    begin
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] r;
        code_t            q;

        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < DIV_DIGIT_W; k++)
        begin
            trial = {r, q[CODE_W-1]};
            q     = {q[CODE_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
                q[0]  = 1'b1;
            end
            r = trial[DIV_W-1:0];
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_CNT_W'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = q;
            rem_next = r;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/pru_pool.sv @@
`timescale 1ns / 1ps

module pru_pool #(
    parameter  int DEPTH = 12,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  pru_pkg::pool_ctl_t  ctl,
    input  logic [IDX_W-1:0]    from,
    input  logic [IDX_W-1:0]    top,
    output pru_pkg::elem_t      head
);
    import pru_pkg::*;

    elem_t pool_reg  [DEPTH];
    elem_t pool_next [DEPTH];

    // Init loads the ascending pool. Shift moves the chosen entry to the top
    // of the live region and closes the gap. Rotate walks the pool past head.
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            pool_next[j] = pool_reg[j];
            if (ctl.init)
            begin
                pool_next[j] = ELEM_W'(j);
            end
            else if (ctl.shift)
            begin
                if (IDX_W'(j) == top)
                begin
                    pool_next[j] = pool_reg[from];
                end
                else if (IDX_W'(j) >= from && IDX_W'(j) < top)
                begin
                    pool_next[j] = pool_reg[(j + 1) % DEPTH];
                end
            end
            else if (ctl.rotate)
            begin
                pool_next[j] = pool_reg[(j + 1) % DEPTH];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            pool_reg[j] <= pool_next[j];
        end
    end

    assign head = pool_reg[0];

endmodule

@@ rtl/permutation_rank_unrank.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Payload
// request   in         operation, element_in, code_in
// result    out        result_kind, code_out, element_out, last
// cfg       in         cfg_wr_en, cfg_wr_data (permutation length)
//
// An element push at position k goes from idle through one compare per stored element
// to the multiply-add fold; the last push then places the code in the output register.
// A decode runs each element through the shared divider (8 radix-16 steps, a start
// and a pool update), then delivers the elements in turn as the result side takes them.
// Reset is asynchronous and active low; the element store is not cleared.
// A stalled result holds the sequencer; pushes that produce no result are
// still taken while an earlier result waits.
module permutation_rank_unrank #(
    parameter int MAX_LEN = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pru_req_if.sink                request,
    pru_res_if.source              result,
    input  logic                   cfg_wr_en,
    input  logic [pru_pkg::LEN_W-1:0] cfg_wr_data
);
    import pru_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_cfg_reg;
    code_t            acc_reg, acc_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] larger_reg, larger_next;
    elem_t            elem_reg, elem_next;
    code_t            code_reg, code_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    code_t            out_code_reg, out_code_next;
    elem_t            out_elem_reg, out_elem_next;
    logic             out_last_reg, out_last_next;

    elem_t            store_reg [MAX_LEN];
    logic             store_we;

    logic [CNT_W-1:0] eff_len;
    logic [IDX_W-1:0] pos_acc;
    logic [CNT_W-1:0] pos_plus1;
    code_t            fold_prod;
    logic [CNT_W-1:0] remaining;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] from;
    logic             out_free;

    pool_ctl_t        pool_ctl;
    elem_t            pool_head;
    logic             div_start;
    logic             div_done;
    code_t            div_quo;
    logic [CNT_W-1:0] div_rem;

    // Length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_cfg_reg <= cfg_wr_data;
        end
    end

    // Length in use: zero acts as one, values past the maximum are clamped.
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (len_cfg_reg > LEN_W'(MAX_LEN))
        begin
            eff_len = CNT_W'(MAX_LEN);
        end
        else
        begin
            eff_len = CNT_W'(len_cfg_reg);
        end
    end

    // Position of an incoming push, held at the last slot of the store.
    assign pos_acc   = (count_reg > IDX_W'(MAX_LEN - 1)) ? IDX_W'(MAX_LEN - 1) : count_reg;
    assign pos_plus1 = CNT_W'(pos_reg) + CNT_W'(1);
    assign fold_prod = acc_reg * CODE_W'(pos_plus1);

    // Decode digit selection.
    assign remaining = eff_len - step_reg;
    assign top       = IDX_W'(remaining - CNT_W'(1));
    assign from      = top - IDX_W'(div_rem);

    assign out_free  = !out_valid_reg || result.ready;
    assign request.ready = (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        larger_next    = larger_reg;
        elem_next      = elem_reg;
        code_next      = code_reg;
        step_next      = step_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_code_next  = out_code_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        store_we       = 1'b0;
        pool_ctl       = '0;
        div_start      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.operation == OP_ENCODE)
                    begin
                        elem_next   = request.element_in;
                        pos_next    = pos_acc;
                        j_next      = '0;
                        larger_next = '0;
                        store_we    = 1'b1;
                        state_next  = (pos_acc == '0) ? S_FOLD : S_CMP;
                    end
                    else
                    begin
                        acc_next      = '0;
                        count_next    = '0;
                        code_next     = request.code_in;
                        step_next     = '0;
                        pool_ctl.init = 1'b1;
                        state_next    = S_DSTART;
                    end
                end
            end

            // Count earlier elements that are larger, one per cycle.
            S_CMP:
            begin
                if (store_reg[j_reg] > elem_reg)
                begin
                    larger_next = larger_reg + IDX_W'(1);
                end
                if (j_reg == pos_reg - IDX_W'(1))
                begin
                    state_next = S_FOLD;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end

            // Fold the digit into the running code.
            S_FOLD:
            begin
                acc_next = fold_prod + CODE_W'(larger_reg);
                if (pos_plus1 >= eff_len)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    count_next = IDX_W'(pos_plus1);
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CODE;
                    out_code_next  = acc_reg;
                    out_elem_next  = '0;
                    out_last_next  = 1'b1;
                    acc_next       = '0;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end

            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end

            // Take one digit out of the divider and update the pool.
            S_DWAIT:
            begin
                if (div_done)
                begin
                    code_next      = div_quo;
                    pool_ctl.shift = 1'b1;
                    step_next      = step_reg + CNT_W'(1);
                    if (step_reg + CNT_W'(1) == eff_len)
                    begin
                        out_idx_next = '0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DSTART;
                    end
                end
            end

            // Deliver the decoded permutation from the head of the pool.
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_ELEM;
                    out_code_next   = '0;
                    out_elem_next   = pool_head;
                    out_last_next   = (out_idx_reg == IDX_W'(eff_len - CNT_W'(1)));
                    pool_ctl.rotate = 1'b1;
                    if (out_idx_reg == IDX_W'(eff_len - CNT_W'(1)))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        larger_reg   <= larger_next;
        elem_reg     <= elem_next;
        code_reg     <= code_next;
        step_reg     <= step_next;
        out_idx_reg  <= out_idx_next;
        out_kind_reg <= out_kind_next;
        out_code_reg <= out_code_next;
        out_elem_reg <= out_elem_next;
        out_last_reg <= out_last_next;
    end

    // Elements of the sequence being encoded.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[pos_acc] <= request.element_in;
        end
    end

    pru_divider #(
        .DIV_W (CNT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (code_reg),
        .divisor   (remaining),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    pru_pool #(
        .DEPTH (MAX_LEN)
    ) u_pool (
        .clk  (clk),
        .ctl  (pool_ctl),
        .from (from),
        .top  (top),
        .head (pool_head)
    );

    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_kind_reg;
    assign result.code_out    = out_code_reg;
    assign result.element_out = out_elem_reg;
    assign result.last        = out_last_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pru_pkg::*;

    localparam int MAX_LEN       = 12;
    localparam int RANDOM_ITEMS  = 205;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 64;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 5000;

    // One result as it leaves the block.
    typedef struct packed {
        logic  kind;
        code_t code;
        elem_t elem;
        logic  last;
    } result_t;

    // Rows of the directed part: a length write or one request.
    typedef enum logic {ROW_LENGTH, ROW_REQUEST} row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        logic      op;
        elem_t     elem;
        code_t     code;
        logic      typed;
        code_t     want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 30;

    // Typed expectations only where the code can be read off directly.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_REQUEST, OP_DECODE, 4'd0,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_DECODE, 4'd7,  32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd1,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd0,  32'd0,         1'b1, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{ROW_REQUEST, OP_DECODE, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd2,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd1,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd0,  32'd0,         1'b1, 32'd1},
        '{ROW_REQUEST, OP_ENCODE, 4'd0,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd15, 32'd0,         1'b1, 32'd0},
        '{ROW_REQUEST, OP_DECODE, 4'd0,  32'd1,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd5,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_DECODE, 4'd0,  32'd2,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd3,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd7,  32'd0,         1'b1, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd9,  32'd0,         1'b1, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd15,        1'b0, 32'd0},
        '{ROW_REQUEST, OP_DECODE, 4'd0,  32'd479001599, 1'b0, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd12,        1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd10, 32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd12, 32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd4,  32'd0,         1'b0, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd2,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd11, 32'd0,         1'b0, 32'd0},
        '{ROW_LENGTH,  OP_ENCODE, 4'd0,  32'd3,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd2,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd1,  32'd0,         1'b0, 32'd0},
        '{ROW_REQUEST, OP_ENCODE, 4'd0,  32'd0,         1'b0, 32'd0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [LEN_W-1:0]  cfg_wr_data;

    pru_req_if req ();
    pru_res_if res ();

    permutation_rank_unrank #(
        .MAX_LEN (MAX_LEN)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (req),
        .result      (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the block's state and length register.
    elem_t            seq_elems [MAX_LEN];
    code_t            rank_acc;
    logic [LEN_W-1:0] seq_count;
    logic [LEN_W-1:0] length_reg;

    result_t fresh_results [$];
    result_t awaited_results [$];

    int failures;
    int stall_cycles;
    int tx_odds;
    int rx_odds;
    bit quiet;
    bit hold_off_request;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Length in force: zero acts as one, anything above the maximum acts as the maximum.
    function automatic int active_length();
        if (length_reg == '0)
            return 1;
        if (int'(length_reg) > MAX_LEN)
            return MAX_LEN;
        return int'(length_reg);
    endfunction

    function automatic code_t perm_count(input int n);
        code_t f;
        f = 1;
        for (int i = 2; i <= n; i++)
            f = f * code_t'(i);
        return f;
    endfunction

    // Works out the results of one accepted request and advances the shadow state.
    task automatic lehmer_step(input logic op, input elem_t e, input code_t c);
        int    eff;
        int    pos;
        int    larger;
        int    rem;
        int    pick;
        elem_t pool [MAX_LEN];
        elem_t chosen;
        code_t rest;

        fresh_results.delete();
        eff = active_length();
        if (op == OP_ENCODE)
        begin
            pos = int'(seq_count);
            if (pos >= MAX_LEN)
                pos = MAX_LEN - 1;
            larger = 0;
            for (int j = 0; j < pos; j++)
                if (seq_elems[j] > e)
                    larger++;
            seq_elems[pos] = e;
            rank_acc = rank_acc * code_t'(pos + 1) + code_t'(larger);
            pos++;
            if (pos >= eff)
            begin
                fresh_results.push_back('{KIND_CODE, rank_acc, elem_t'(0), 1'b1});
                rank_acc  = '0;
                seq_count = '0;
            end
            else
                seq_count = LEN_W'(pos);
        end
        else
        begin
            // A decode drops any sequence in progress.
            rank_acc  = '0;
            seq_count = '0;
            rest      = c;
            for (int i = 0; i < eff; i++)
                pool[i] = elem_t'(i);
            for (int i = 0; i < eff; i++)
            begin
                rem    = eff - i;
                pick   = (rem - 1) - int'(rest % code_t'(rem));
                chosen = pool[pick];
                rest   = rest / code_t'(rem);
                for (int j = pick; j < rem - 1; j++)
                    pool[j] = pool[j + 1];
                pool[rem - 1] = chosen;
            end
            for (int i = 0; i < eff; i++)
                fresh_results.push_back('{KIND_ELEM, code_t'(0), pool[i], i == eff - 1});
        end
    endtask

    // Offers one request, waits for it to be taken and records what it should produce.
    task automatic issue_request(input logic op, input elem_t e, input code_t c,
                                 input logic typed, input code_t want);
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.element_in <= e;
        req.code_in    <= c;
        do
            @(posedge clk);
        while (!req.ready);
        lehmer_step(op, e, c);
        if (typed && fresh_results.size() != 0)
            fresh_results[0].code = want;
        foreach (fresh_results[i])
            awaited_results.push_back(fresh_results[i]);
    endtask

    // Random burst of idle cycles on the request side.
    task automatic sender_gap();
        if (!quiet && tx_odds != 0 && $urandom_range(1, tx_odds + 1) == 1)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Length writes happen only with the block drained and settled.
    task automatic write_length(input logic [LEN_W-1:0] value);
        req.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        length_reg  = value;
    endtask

    // Result side: random stalls, one long hold-off on request, quiet at the end.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            if (hold_off_request)
            begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (!quiet && rx_odds != 0 && $urandom_range(1, rx_odds + 1) == 1)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                res.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;

        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.result_kind, res.code_out, res.element_out, res.last};
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result: kind %0d code %0h elem %0d last %0d",
                             got.kind, got.code, got.elem, got.last);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind || got.code !== want.code ||
                    got.elem !== want.elem || got.last !== want.last)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("Mismatch: expected kind %0d code %0h elem %0d last %0d",
                                 want.kind, want.code, want.elem, want.last);
                        $display("          got      kind %0d code %0h elem %0d last %0d",
                                 got.kind, got.code, got.elem, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side ends the run.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   random_sent;
        int   phase;
        int   phase_items;
        int   phase_sent;
        int   eff;
        int   choice;
        int   cut;
        int   swap_at;
        int   tmp;
        int   perm [MAX_LEN];
        logic [LEN_W-1:0] phase_len;

        req.valid        = 1'b0;
        req.operation    = OP_ENCODE;
        req.element_in   = '0;
        req.code_in      = '0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        failures         = 0;
        stall_cycles     = 0;
        tx_odds          = 3;
        rx_odds          = 3;
        quiet            = 1'b0;
        hold_off_request = 1'b0;
        rank_acc         = '0;
        seq_count        = '0;
        length_reg       = LEN_RESET;
        foreach (seq_elems[i])
            seq_elems[i] = '0;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, both operations and the special cases.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_LENGTH)
                write_length(LEN_W'(DIRECTED[r].code));
            else
            begin
                sender_gap();
                issue_request(DIRECTED[r].op, DIRECTED[r].elem, DIRECTED[r].code,
                              DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // Random part, in phases separated by a drained block and a new length.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
                phase_len = LEN_W'(12);
            else if (phase == 1)
                phase_len = LEN_W'(1);
            else if ($urandom_range(0, 5) == 0)
                phase_len = ($urandom_range(0, 3) == 0) ? LEN_W'(0)
                                                        : LEN_W'($urandom_range(13, 15));
            else
                phase_len = LEN_W'($urandom_range(1, 12));
            write_length(phase_len);

            quiet       = (random_sent >= RANDOM_ITEMS - 45);
            tx_odds     = $urandom_range(0, 4);
            rx_odds     = $urandom_range(0, 4);
            phase_items = $urandom_range(15, 30);
            phase_sent  = 0;

            // Hold the result side off while requests keep coming, so the block backs up.
            if (phase == 2)
            begin
                hold_off_request = 1'b1;
                tx_odds          = 0;
            end

            while (phase_sent < phase_items)
            begin
                eff    = active_length();
                choice = $urandom_range(0, 9);
                if (choice <= 5)
                begin
                    // A permutation of the active length, sometimes cut short.
                    for (int i = 0; i < eff; i++)
                        perm[i] = i;
                    for (int i = eff - 1; i > 0; i--)
                    begin
                        swap_at       = $urandom_range(0, i);
                        tmp           = perm[i];
                        perm[i]       = perm[swap_at];
                        perm[swap_at] = tmp;
                    end
                    cut = eff;
                    if (choice == 5 && eff > 1)
                        cut = $urandom_range(1, eff - 1);
                    for (int k = 0; k < cut; k++)
                    begin
                        sender_gap();
                        issue_request(OP_ENCODE, elem_t'(perm[k]), $urandom(), 1'b0, '0);
                        phase_sent++;
                    end
                end
                else if (choice <= 7)
                begin
                    sender_gap();
                    issue_request(OP_DECODE, elem_t'($urandom_range(0, 15)),
                                  $urandom_range(0, perm_count(eff) - 1), 1'b0, '0);
                    phase_sent++;
                end
                else if (choice == 8)
                begin
                    sender_gap();
                    issue_request(OP_DECODE, elem_t'($urandom_range(0, 15)), $urandom(),
                                  1'b0, '0);
                    phase_sent++;
                end
                else
                begin
                    sender_gap();
                    issue_request(OP_ENCODE, elem_t'($urandom_range(0, 15)), $urandom(),
                                  1'b0, '0);
                    phase_sent++;
                end
            end
            random_sent += phase_sent;
            phase++;
        end

        // Drain, then let the block settle before the verdict.
        req.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ permutation_rank_unrank.f @@
rtl/pru_pkg.sv
rtl/pru_channels.sv
rtl/pru_divider.sv
rtl/pru_pool.sv
rtl/permutation_rank_unrank.sv
sim/tb.sv
